// File: rtl/core/pds_pkg.sv
package pds_pkg;

	// field widths fixed by the report format
	localparam int unsigned MOVE_W     = 8;
	localparam int unsigned STAMP_W    = 32;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned THR_W      = 3;
	localparam int unsigned CFG_IDX_W  = 3;

	// register reset values
	localparam logic [INTERVAL_W-1:0] FAST_RESET   = 16'd75;
	localparam logic [INTERVAL_W-1:0] MEDIUM_RESET = 16'd90;
	localparam logic [INTERVAL_W-1:0] PRIOR_RESET  = 16'd50;
	localparam logic [INTERVAL_W-1:0] IDLE_RESET   = 16'd150;
	localparam logic [THR_W-1:0]      THR_RESET    = 3'd1;

	typedef logic signed [MOVE_W-1:0] move_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST   = 3'd0,
		CFG_MEDIUM = 3'd1,
		CFG_PRIOR  = 3'd2,
		CFG_IDLE   = 3'd3,
		CFG_OFFSET = 3'd4
	} cfg_reg_t;

	// interval verdict carried from the accept stage to the output stage
	typedef struct packed {
		logic pass;
		logic idle;
	} verdict_t;

endpackage

// File: rtl/core/pds_if.sv
interface pds_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [pds_pkg::MOVE_W-1:0]   move_x;
	logic signed [pds_pkg::MOVE_W-1:0]   move_y;
	logic        [pds_pkg::STAMP_W-1:0]  stamp_ms;

	modport source (output valid, move_x, move_y, stamp_ms, input ready);
	modport sink (input valid, move_x, move_y, stamp_ms, output ready);
endinterface

interface pds_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [pds_pkg::MOVE_W-1:0] out_x;
	logic signed [pds_pkg::MOVE_W-1:0] out_y;
	logic                              idle_zeroed;
	logic                              drift_x;
	logic                              drift_y;

	modport source (output valid, out_x, out_y, idle_zeroed, drift_x, drift_y,
		input ready);
	modport sink (input valid, out_x, out_y, idle_zeroed, drift_x, drift_y,
		output ready);
endinterface

// File: rtl/core/pds_cell.sv
module pds_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  pds_pkg::move_t              din,
	input  logic [pds_pkg::THR_W-1:0]   thr,
	output pds_pkg::move_t              dout,
	output logic                        in_band
);
	import pds_pkg::*;

	move_t                  tap_q;
	logic  [MOVE_W:0]       mag;

	// one window tap, handed on to the neighbor on every beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= din;
		end
	end

	// magnitude against the jitter threshold
	always_comb begin
		if (tap_q[MOVE_W-1]) begin
			mag = (MOVE_W+1)'(0) - {tap_q[MOVE_W-1], tap_q};
		end else begin
			mag = {1'b0, tap_q};
		end
	end

	assign in_band = (mag <= (MOVE_W+1)'(thr));
	assign dout    = tap_q;

endmodule

// File: rtl/core/pds_axis.sv
module pds_axis #(
	parameter int unsigned WINDOW_DEPTH = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  pds_pkg::move_t              din,
	input  logic [pds_pkg::THR_W-1:0]   thr,
	output logic                        drift
);
	import pds_pkg::*;

	localparam int unsigned SUM_W = MOVE_W + $clog2(WINDOW_DEPTH);

	move_t                    taps [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]  in_band;
	logic signed [SUM_W-1:0]  sum_q;

	// row of cells, newest at the head
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		move_t cell_in;
		if (i == 0) begin : g_head
			assign cell_in = din;
		end else begin : g_body
			assign cell_in = taps[i-1];
		end
		pds_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.din     (cell_in),
			.thr     (thr),
			.dout    (taps[i]),
			.in_band (in_band[i])
		);
	end

	// running window sum: add the entering value, drop the leaving one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_q + SUM_W'(din) - SUM_W'(taps[WINDOW_DEPTH-1]);
		end
	end

	assign drift = (&in_band) && (sum_q != '0);

endmodule

// File: rtl/core/pointer_drift_suppressor_top.sv
// Drift filter for a pointing stick. One report is taken per clock cycle unless the
// input stalls. The accept edge shifts the report into a row of window cells (one cell
// per sample for each axis, with a running sum beside it) and latches the interval
// verdict in stage one, and the output register then takes the result from the
// updated window once it is free or drains. A full output register refills in the
// cycle the sink takes its beat; the input stalls only while stage one and the output
// register are both full and the sink holds off.
// Reports arriving faster than the fast limit, or faster than the medium limit
// after a short prior interval, pass unchanged; a gap above the idle limit zeroes
// both axes; otherwise an axis whose window stays within the offset threshold with
// a nonzero sum is zeroed. Configuration takes effect on the next report and
// should only be written while no report is in flight.
module pointer_drift_suppressor_top #(
	parameter int unsigned WINDOW_DEPTH = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [pds_pkg::CFG_IDX_W-1:0]         wr_index,
	input  logic [pds_pkg::INTERVAL_W-1:0]        wr_data,
	pds_in_if.sink                                report,
	pds_out_if.source                             result
);
	import pds_pkg::*;

	logic [INTERVAL_W-1:0] fast_q;
	logic [INTERVAL_W-1:0] medium_q;
	logic [INTERVAL_W-1:0] prior_q;
	logic [INTERVAL_W-1:0] idle_q;
	logic [THR_W-1:0]      thr_q;

	logic [STAMP_W-1:0]    stamp0_q;
	logic [STAMP_W-1:0]    stamp1_q;
	logic [STAMP_W-1:0]    latest;
	logic [STAMP_W-1:0]    previous;

	logic                  accept;
	logic                  advance;
	logic                  valid_s1;
	verdict_t              verdict;
	verdict_t              verdict_s1;
	move_t                 x_s1;
	move_t                 y_s1;
	logic                  drift_x;
	logic                  drift_y;

	logic                  out_valid_q;
	move_t                 out_x_q;
	move_t                 out_y_q;
	logic                  idle_zeroed_q;
	logic                  drift_x_q;
	logic                  drift_y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q   <= FAST_RESET;
			medium_q <= MEDIUM_RESET;
			prior_q  <= PRIOR_RESET;
			idle_q   <= IDLE_RESET;
			thr_q    <= THR_RESET;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				CFG_FAST:   fast_q   <= wr_data;
				CFG_MEDIUM: medium_q <= wr_data;
				CFG_PRIOR:  prior_q  <= wr_data;
				CFG_IDLE:   idle_q   <= wr_data;
				CFG_OFFSET: thr_q    <= wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage one moves on when the output register is free or drains
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign report.ready = !valid_s1 || advance;
	assign accept       = report.valid && report.ready;

	// intervals against the two stored stamps
	assign latest   = report.stamp_ms - stamp0_q;
	assign previous = stamp0_q - stamp1_q;

	always_comb begin
		verdict.pass = (latest < STAMP_W'(fast_q))
			|| ((latest < STAMP_W'(medium_q)) && (previous < STAMP_W'(prior_q)));
		verdict.idle = (latest > STAMP_W'(idle_q));
	end

	// stamp history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp0_q <= '0;
			stamp1_q <= '0;
		end else if (accept) begin
			stamp0_q <= report.stamp_ms;
			stamp1_q <= stamp0_q;
		end
	end

	// movement windows
	pds_axis #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.din    (report.move_x),
		.thr    (thr_q),
		.drift  (drift_x)
	);

	pds_axis #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.din    (report.move_y),
		.thr    (thr_q),
		.drift  (drift_y)
	);

	// stage one: accepted beat and its interval verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			verdict_s1 <= verdict;
			x_s1       <= report.move_x;
			y_s1       <= report.move_y;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (verdict_s1.pass) begin
				out_x_q       <= x_s1;
				out_y_q       <= y_s1;
				idle_zeroed_q <= 1'b0;
				drift_x_q     <= 1'b0;
				drift_y_q     <= 1'b0;
			end else if (verdict_s1.idle) begin
				out_x_q       <= '0;
				out_y_q       <= '0;
				idle_zeroed_q <= 1'b1;
				drift_x_q     <= 1'b0;
				drift_y_q     <= 1'b0;
			end else begin
				out_x_q       <= drift_x ? move_t'(0) : x_s1;
				out_y_q       <= drift_y ? move_t'(0) : y_s1;
				idle_zeroed_q <= 1'b0;
				drift_x_q     <= drift_x;
				drift_y_q     <= drift_y;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_x       = out_x_q;
	assign result.out_y       = out_y_q;
	assign result.idle_zeroed = idle_zeroed_q;
	assign result.drift_x     = drift_x_q;
	assign result.drift_y     = drift_y_q;

endmodule

// File: bench/pds_suppress_checker.sv
module pds_suppress_checker #(
	parameter int unsigned DEPTH = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [pds_pkg::CFG_IDX_W-1:0]         wr_index,
	input  logic [pds_pkg::INTERVAL_W-1:0]        wr_data,
	pds_in_if                                     report,
	pds_out_if                                    result,
	output int unsigned                           errors,
	output int unsigned                           pending,
	output int unsigned                           reports_seen,
	output int unsigned                           idle_seen,
	output int unsigned                           drift_x_seen,
	output int unsigned                           drift_y_seen
);
	import pds_pkg::*;

	typedef struct packed {
		move_t x;
		move_t y;
		logic  idle;
		logic  dx;
		logic  dy;
	} filtered_t;

	// programmed limits as the block should hold them
	logic [INTERVAL_W-1:0] fast_lim;
	logic [INTERVAL_W-1:0] medium_lim;
	logic [INTERVAL_W-1:0] prior_lim;
	logic [INTERVAL_W-1:0] idle_lim;
	logic [THR_W-1:0]      jitter_lim;

	// movement and stamp history, newest at index 0
	move_t              x_hist [DEPTH];
	move_t              y_hist [DEPTH];
	logic [STAMP_W-1:0] stamp_hist [3];

	filtered_t awaited_moves [$];
	filtered_t want;
	logic      mism;

	// axis counts as drift when every sample is small and the sum is nonzero
	function automatic logic axis_drifts(input move_t w [DEPTH]);
		int total;
		int mag;
		logic ok;
		total = 0;
		ok = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			mag = (w[i] < 0) ? -int'(w[i]) : int'(w[i]);
			if (mag > int'(jitter_lim))
				ok = 1'b0;
			total += int'(w[i]);
		end
		return ok && (total != 0);
	endfunction

	// shift one report into the history and decide what comes out
	function automatic filtered_t filter_report(input move_t mx, input move_t my,
		input logic [STAMP_W-1:0] stamp);
		filtered_t r;
		logic [STAMP_W-1:0] latest;
		logic [STAMP_W-1:0] previous;
		for (int i = DEPTH - 1; i > 0; i--) begin
			x_hist[i] = x_hist[i-1];
			y_hist[i] = y_hist[i-1];
		end
		stamp_hist[2] = stamp_hist[1];
		stamp_hist[1] = stamp_hist[0];
		x_hist[0] = mx;
		y_hist[0] = my;
		stamp_hist[0] = stamp;
		latest = stamp_hist[0] - stamp_hist[1];
		previous = stamp_hist[1] - stamp_hist[2];

		r = '{x: mx, y: my, idle: 1'b0, dx: 1'b0, dy: 1'b0};
		if (latest < STAMP_W'(fast_lim)) begin
			// quick report, human input
		end else if (latest < STAMP_W'(medium_lim) && previous < STAMP_W'(prior_lim)) begin
			// two short intervals in a row, human input
		end else if (latest > STAMP_W'(idle_lim)) begin
			r.x = '0;
			r.y = '0;
			r.idle = 1'b1;
		end else begin
			if (axis_drifts(x_hist)) begin
				r.x = '0;
				r.dx = 1'b1;
			end
			if (axis_drifts(y_hist)) begin
				r.y = '0;
				r.dy = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_lim = FAST_RESET;
			medium_lim = MEDIUM_RESET;
			prior_lim = PRIOR_RESET;
			idle_lim = IDLE_RESET;
			jitter_lim = THR_RESET;
			for (int i = 0; i < DEPTH; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				stamp_hist[i] = '0;
			awaited_moves.delete();
			errors = 0;
			pending = 0;
			reports_seen = 0;
			idle_seen = 0;
			drift_x_seen = 0;
			drift_y_seen = 0;
		end else begin
			// register writes, unknown indexes fall through
			if (wr_en) begin
				case (wr_index)
					CFG_FAST:   fast_lim = wr_data;
					CFG_MEDIUM: medium_lim = wr_data;
					CFG_PRIOR:  prior_lim = wr_data;
					CFG_IDLE:   idle_lim = wr_data;
					CFG_OFFSET: jitter_lim = wr_data[THR_W-1:0];
					default: ;
				endcase
			end

			// input beat
			if (report.valid && report.ready) begin
				awaited_moves.push_back(filter_report(report.move_x, report.move_y,
					report.stamp_ms));
				reports_seen++;
			end

			// output beat against the oldest expectation
			if (result.valid && result.ready) begin
				if (awaited_moves.size() == 0) begin
					if (errors < 20)
						$display("%0t: unexpected result x=%0d y=%0d idle=%b dx=%b dy=%b",
							$time, result.out_x, result.out_y, result.idle_zeroed,
							result.drift_x, result.drift_y);
					errors++;
				end else begin
					want = awaited_moves.pop_front();
					mism = 1'b0;
					if (result.out_x !== want.x) begin
						mism = 1'b1;
						if (errors < 20)
							$display("%0t: out_x expected %0d got %0d", $time, want.x,
								result.out_x);
					end
					if (result.out_y !== want.y) begin
						mism = 1'b1;
						if (errors < 20)
							$display("%0t: out_y expected %0d got %0d", $time, want.y,
								result.out_y);
					end
					if (result.idle_zeroed !== want.idle) begin
						mism = 1'b1;
						if (errors < 20)
							$display("%0t: idle_zeroed expected %b got %b", $time, want.idle,
								result.idle_zeroed);
					end
					if (result.drift_x !== want.dx) begin
						mism = 1'b1;
						if (errors < 20)
							$display("%0t: drift_x expected %b got %b", $time, want.dx,
								result.drift_x);
					end
					if (result.drift_y !== want.dy) begin
						mism = 1'b1;
						if (errors < 20)
							$display("%0t: drift_y expected %b got %b", $time, want.dy,
								result.drift_y);
					end
					if (mism)
						errors++;
					idle_seen += 32'(want.idle);
					drift_x_seen += 32'(want.dx);
					drift_y_seen += 32'(want.dy);
				end
			end
			pending = awaited_moves.size();
		end
	end

endmodule

// File: bench/tb_pointer_drift_suppressor_top.sv
module tb_pointer_drift_suppressor_top;
	import pds_pkg::*;

	localparam int unsigned DEPTH          = 10;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned PHASES         = 12;
	localparam int unsigned PHASE_REPORTS  = 130;

	typedef enum int unsigned {
		BURST_DRIFT,
		BURST_HUMAN,
		BURST_NOISE
	} burst_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [INTERVAL_W-1:0] wr_data;

	pds_in_if  report ();
	pds_out_if result ();

	int unsigned errors;
	int unsigned pending;
	int unsigned reports_seen;
	int unsigned idle_seen;
	int unsigned drift_x_seen;
	int unsigned drift_y_seen;
	int unsigned quiet_cycles;

	// stimulus side controls
	logic hold_req;
	logic hold_done;
	logic no_idle;

	// limits last programmed, used only to aim the stimulus
	logic [INTERVAL_W-1:0] fast_lim;
	logic [INTERVAL_W-1:0] medium_lim;
	logic [INTERVAL_W-1:0] prior_lim;
	logic [INTERVAL_W-1:0] idle_lim;
	logic [THR_W-1:0]      jitter_lim;
	logic [STAMP_W-1:0]    last_stamp;

	pointer_drift_suppressor_top #(
		.WINDOW_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.report   (report),
		.result   (result)
	);

	pds_suppress_checker #(
		.DEPTH(DEPTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.report       (report),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.reports_seen (reports_seen),
		.idle_seen    (idle_seen),
		.drift_x_seen (drift_x_seen),
		.drift_y_seen (drift_y_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle stretch length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// movement within +/- the jitter limit, with an occasional outlier
	function automatic move_t jitter_move();
		int v;
		v = int'($urandom_range(0, 2 * int'(jitter_lim))) - int'(jitter_lim);
		if ($urandom_range(0, 11) == 0)
			return move_t'($urandom);
		return move_t'(v);
	endfunction

	// time since the last report, aimed at the decision bands
	function automatic logic [STAMP_W-1:0] pick_interval(input burst_kind_t kind);
		int unsigned r;
		int unsigned lo;
		int unsigned hi;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 6))
				0: return STAMP_W'(fast_lim) - 1;
				1: return STAMP_W'(fast_lim);
				2: return STAMP_W'(medium_lim) - 1;
				3: return STAMP_W'(medium_lim);
				4: return STAMP_W'(prior_lim);
				5: return STAMP_W'(idle_lim);
				default: return STAMP_W'(idle_lim) + 1;
			endcase
		end
		case (kind)
			BURST_DRIFT: begin
				lo = 32'(fast_lim);
				hi = 32'(idle_lim);
				if (lo > hi)
					return $urandom_range(hi, lo);
				return $urandom_range(lo, hi);
			end
			BURST_HUMAN: return $urandom_range(0, int'(medium_lim) + 10);
			default: begin
				if (r < 55)
					return $urandom;
				return $urandom_range(0, 2 * int'(idle_lim) + 2);
			end
		endcase
	endfunction

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [INTERVAL_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// all five limits plus a write to an unused index
	task automatic program_limits(input logic [INTERVAL_W-1:0] f, input logic [INTERVAL_W-1:0] m,
		input logic [INTERVAL_W-1:0] p, input logic [INTERVAL_W-1:0] i,
		input logic [THR_W-1:0] t);
		logic [CFG_IDX_W-1:0] unused_idx;
		unused_idx = CFG_OFFSET + CFG_IDX_W'($urandom_range(1, 3));
		put_reg(CFG_FAST, f);
		put_reg(CFG_MEDIUM, m);
		put_reg(CFG_PRIOR, p);
		put_reg(CFG_IDLE, i);
		put_reg(CFG_OFFSET, {13'($urandom), t});
		put_reg(unused_idx, 16'($urandom));
		wr_en <= 1'b0;
		fast_lim = f;
		medium_lim = m;
		prior_lim = p;
		idle_lim = i;
		jitter_lim = t;
	endtask

	// one report beat, then an optional idle stretch
	task automatic send_report(input move_t x, input move_t y, input logic [STAMP_W-1:0] stamp);
		logic fire;
		int unsigned pause;
		report.valid <= 1'b1;
		report.move_x <= x;
		report.move_y <= y;
		report.stamp_ms <= stamp;
		do begin
			@(negedge clk);
			fire = report.valid && report.ready;
			@(posedge clk);
		end while (!fire);
		last_stamp = stamp;
		pause = idle_len();
		if (pause > 0) begin
			report.valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	task automatic send_after(input move_t x, input move_t y, input logic [STAMP_W-1:0] delta);
		send_report(x, y, last_stamp + delta);
	endtask

	// wait until every result is back and the pipe has gone quiet
	task automatic drain();
		report.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: random ready runs and stalls, one long hold-off on request
	initial begin : sink_side
		int unsigned stall;
		result.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			result.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no beat and no register write
	always @(posedge clk) begin
		if (!arst_n || wr_en || (report.valid && report.ready) ||
			(result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		burst_kind_t kind;
		int unsigned sent;
		int unsigned burst;
		move_t mx;
		move_t my;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= CFG_FAST;
		wr_data <= '0;
		report.valid <= 1'b0;
		report.move_x <= '0;
		report.move_y <= '0;
		report.stamp_ms <= '0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		no_idle = 1'b0;
		quiet_cycles = 0;
		fast_lim = FAST_RESET;
		medium_lim = MEDIUM_RESET;
		prior_lim = PRIOR_RESET;
		idle_lim = IDLE_RESET;
		jitter_lim = THR_RESET;
		last_stamp = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limits, first report measured from stamp zero
		send_report(8'sd127, -8'sd128, 32'd200);
		send_after(-8'sd128, 8'sd127, 32'd10);
		send_after(8'sd1, -8'sd1, 32'd80);
		send_after(8'sd0, 8'sd0, 32'd80);
		send_after(-8'sd1, 8'sd1, 32'd74);
		send_after(8'sd5, 8'sd5, 32'd75);
		send_after(8'sd0, 8'sd0, 32'd89);
		send_after(8'sd0, 8'sd0, 32'd150);
		send_after(8'sd0, 8'sd0, 32'd151);
		send_after(8'sd0, 8'sd0, 32'd49);
		send_after(8'sd0, 8'sd0, 32'd89);
		send_after(8'sd0, 8'sd0, 32'd89);
		// small steady x drifts, alternating y sums to zero
		for (int k = 0; k < 11; k++)
			send_after(8'sd1, (k % 2 == 1) ? -8'sd1 : 8'sd1, 32'd100);
		// stamp wraps across zero
		send_report(-8'sd1, 8'sd0, 32'hFFFF_FFC0);
		send_report(-8'sd1, 8'sd1, 32'h0000_0024);

		// random phases over several limit settings
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: program_limits(FAST_RESET, MEDIUM_RESET, PRIOR_RESET, IDLE_RESET, THR_RESET);
				1: program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0);
				2: program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
				3: program_limits(FAST_RESET, MEDIUM_RESET, PRIOR_RESET, IDLE_RESET, 3'd4);
				default: program_limits(16'($urandom_range(0, 200)), 16'($urandom_range(0, 250)),
					16'($urandom_range(0, 120)), 16'($urandom_range(0, 400)),
					3'($urandom_range(0, 7)));
			endcase
			no_idle = (phase == 5 || phase == 6);
			hold_req = (phase == 5);
			sent = 0;
			while (sent < PHASE_REPORTS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: kind = BURST_DRIFT;
					5, 6, 7: kind = BURST_HUMAN;
					default: kind = BURST_NOISE;
				endcase
				burst = (kind == BURST_DRIFT) ? $urandom_range(10, 14) : $urandom_range(1, 6);
				for (int k = 0; k < burst; k++) begin
					if (kind == BURST_DRIFT) begin
						mx = jitter_move();
						my = jitter_move();
					end else begin
						mx = move_t'($urandom);
						my = move_t'($urandom);
					end
					send_after(mx, my, pick_interval(kind));
					sent++;
				end
			end
		end

		drain();
		$display("run covered %0d reports under %0d limit settings", reports_seen, PHASES + 1);
		$display("zeroed: %0d on idle gaps, %0d x drift, %0d y drift",
			idle_seen, drift_x_seen, drift_y_seen);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
